### rtl/core/hmf_pkg.sv
// hmf_pkg: shared types and constants of the hid message fragmenter
// holds the port word structs, the queue entry struct and the header codes
// no dependencies
package hmf_pkg;

	// header bytes of an init report: channel (4), command, length (2)
	localparam int unsigned INIT_HDR_BYTES = 7;
	// header bytes of a continuation report: channel (4), sequence
	localparam int unsigned CONT_HDR_BYTES = 5;

	// header kind carried by a queue entry
	localparam logic [1:0] HDR_NONE = 2'd0;
	localparam logic [1:0] HDR_INIT = 2'd1;
	localparam logic [1:0] HDR_CONT = 2'd2;

	// input word
	typedef struct packed {
		logic [31:0] channel_id;
		logic [7:0]  command_byte;
		logic [15:0] message_length;
		logic [7:0]  data_byte;
		logic        empty_message;
	} in_word_t;

	// output word
	typedef struct packed {
		logic [7:0] report_byte;
		logic       end_of_report;
		logic       end_of_message;
	} out_word_t;

	// classified work for the back end: one accepted word
	typedef struct packed {
		logic [1:0]  hdr;
		logic [31:0] channel_id;
		logic [7:0]  command_byte;
		logic [15:0] message_length;
		logic [7:0]  seq;
		logic [7:0]  data_byte;
		logic        has_data;
		logic        finish;
		logic        last;
	} entry_t;

endpackage

### rtl/core/hid_message_fragmenter.sv
// hid_message_fragmenter: top level of the hid report fragmenter
// instantiates hmf_front, hmf_queue and hmf_back; depends on hmf_pkg
//
// Usage: each input word on in_valid/in_ready carries one payload byte of a
// response message; channel_id, command_byte, message_length and
// empty_message are taken from the first word of a message and ignored after.
// A message of length zero, or a word with empty_message set while idle,
// yields one init report carrying length 0. Output words on
// out_valid/out_ready carry one report byte each, with end_of_report on the
// last byte of every REPORT_BYTES-byte report and end_of_message on the
// last byte of the message.
// A taken word is held in the queue and then in the output register.
// Throughput: the back end emits one byte per cycle while the queue holds an
// entry and the receiver takes its bytes; a word yields its header bytes
// (7 init, 5 continuation), its payload byte and any padding bytes.
// The front end takes a word every cycle while the two-entry queue has room.
// Reset clears the framing state, the queue and the output valid flag; no
// message is in progress afterwards. When the receiver stalls, the output
// word holds, the queue fills, and in_ready drops.
module hid_message_fragmenter #(
	parameter int unsigned REPORT_BYTES       = 64,
	parameter int unsigned INIT_PAYLOAD_BYTES = 57,
	parameter int unsigned CONT_PAYLOAD_BYTES = 59
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hmf_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hmf_pkg::out_word_t out_data
);

	localparam int unsigned INIT_SPACE = REPORT_BYTES - hmf_pkg::INIT_HDR_BYTES;
	localparam int unsigned CONT_SPACE = REPORT_BYTES - hmf_pkg::CONT_HDR_BYTES;
	localparam int unsigned INIT_ROOM  =
		(INIT_PAYLOAD_BYTES < INIT_SPACE) ? INIT_PAYLOAD_BYTES : INIT_SPACE;
	localparam int unsigned CONT_ROOM  =
		(CONT_PAYLOAD_BYTES < CONT_SPACE) ? CONT_PAYLOAD_BYTES : CONT_SPACE;

	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_not_empty;
	hmf_pkg::entry_t wr_entry;
	hmf_pkg::entry_t rd_entry;

	// classify incoming words
	hmf_front #(
		.INIT_ROOM (INIT_ROOM),
		.CONT_ROOM (CONT_ROOM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (wr_entry)
	);

	// decoupling queue
	hmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (wr_entry),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.rd_entry  (rd_entry)
	);

	// emit report bytes
	hmf_back #(
		.REPORT_BYTES (REPORT_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_entry     (rd_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

### rtl/core/hmf_front.sv
// hmf_front: accepts input words, tracks message framing and classifies each word
// into a queue entry (header kind, payload byte, report finish flags)
// depends on hmf_pkg
module hmf_front #(
	parameter int unsigned INIT_ROOM = 57,
	parameter int unsigned CONT_ROOM = 59
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hmf_pkg::in_word_t in_data,
	input  logic             q_full,
	output logic             q_push,
	output hmf_pkg::entry_t  q_entry
);

	localparam int unsigned ROOM_MAX = (INIT_ROOM > CONT_ROOM) ? INIT_ROOM : CONT_ROOM;
	localparam int unsigned CNT_W = $clog2(ROOM_MAX + 1);

	logic             active_q;
	logic             first_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      sent_q;
	logic [7:0]       seq_q;
	logic [31:0]      chan_q;
	logic [7:0]       cmd_q;
	logic [15:0]      len_q;

	logic             new_msg;
	logic [15:0]      len_new;
	logic             zero_len;
	logic [31:0]      eff_chan;
	logic [7:0]       eff_cmd;
	logic [15:0]      eff_len;
	logic             eff_first;
	logic [CNT_W-1:0] eff_cnt;
	logic [15:0]      eff_sent;
	logic [7:0]       eff_seq;
	logic [15:0]      sent_nx;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] room;
	logic             done;
	logic             full;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// pick the framing context: fresh message or the one in progress
	always_comb begin
		new_msg   = !active_q;
		len_new   = in_data.empty_message ? 16'd0 : in_data.message_length;
		zero_len  = new_msg && (len_new == 16'd0);
		eff_chan  = new_msg ? in_data.channel_id   : chan_q;
		eff_cmd   = new_msg ? in_data.command_byte : cmd_q;
		eff_len   = new_msg ? len_new : len_q;
		eff_first = new_msg || first_q;
		eff_cnt   = new_msg ? '0 : cnt_q;
		eff_sent  = new_msg ? 16'd0 : sent_q;
		eff_seq   = new_msg ? 8'd0 : seq_q;
		sent_nx   = eff_sent + 16'd1;
		cnt_inc   = eff_cnt + CNT_W'(1);
		room      = eff_first ? CNT_W'(INIT_ROOM) : CNT_W'(CONT_ROOM);
		done      = (sent_nx == eff_len);
		full      = (cnt_inc == room);
	end

	// classify the word
	always_comb begin
		q_entry.channel_id     = eff_chan;
		q_entry.command_byte   = eff_cmd;
		q_entry.message_length = eff_len;
		q_entry.seq            = eff_seq;
		q_entry.data_byte      = in_data.data_byte;
		if (zero_len) begin
			q_entry.hdr      = hmf_pkg::HDR_INIT;
			q_entry.has_data = 1'b0;
			q_entry.finish   = 1'b1;
			q_entry.last     = 1'b1;
		end else begin
			if (eff_cnt == '0) begin
				q_entry.hdr = eff_first ? hmf_pkg::HDR_INIT : hmf_pkg::HDR_CONT;
			end else begin
				q_entry.hdr = hmf_pkg::HDR_NONE;
			end
			q_entry.has_data = 1'b1;
			q_entry.finish   = done || full;
			q_entry.last     = done;
		end
	end

	// framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			first_q  <= 1'b0;
			cnt_q    <= '0;
			sent_q   <= 16'd0;
			seq_q    <= 8'd0;
		end else if (q_push) begin
			if (zero_len) begin
				active_q <= 1'b0;
			end else begin
				active_q <= !done;
				sent_q   <= sent_nx;
				cnt_q    <= (done || full) ? '0 : cnt_inc;
				first_q  <= eff_first && !(done || full);
				seq_q    <= (q_entry.hdr == hmf_pkg::HDR_CONT) ? (eff_seq + 8'd1) : eff_seq;
			end
		end
	end

	// message header fields, taken when a message starts
	always_ff @(posedge clk) begin
		if (q_push && new_msg) begin
			chan_q <= eff_chan;
			cmd_q  <= eff_cmd;
			len_q  <= eff_len;
		end
	end

endmodule

### rtl/core/hmf_queue.sv
// hmf_queue: two-entry queue of classified words between front and back end
// depends on hmf_pkg
module hmf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hmf_pkg::entry_t wr_entry,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output hmf_pkg::entry_t rd_entry
);

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	hmf_pkg::entry_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

### rtl/core/hmf_back.sv
// hmf_back: walks each queue entry through header, payload and padding bytes
// and drives the registered output word
// depends on hmf_pkg
module hmf_back #(
	parameter int unsigned REPORT_BYTES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  hmf_pkg::entry_t    q_entry,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output hmf_pkg::out_word_t out_data
);

	localparam int unsigned POS_W = $clog2(REPORT_BYTES);

	localparam logic [1:0] ST_HDR  = 2'd0;
	localparam logic [1:0] ST_DATA = 2'd1;
	localparam logic [1:0] ST_PAD  = 2'd2;

	logic [1:0]         state_q;
	logic [2:0]         idx_q;
	logic [POS_W-1:0]   pos_q;
	logic               out_valid_q;
	hmf_pkg::out_word_t out_q;

	logic               advance;
	logic [1:0]         eff_state;
	logic               pos_last;
	logic               hdr_last;
	logic [1:0]         state_nx;
	logic [2:0]         idx_nx;
	logic [POS_W-1:0]   pos_nx;
	hmf_pkg::out_word_t word;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign advance   = q_not_empty && (!out_valid_q || out_ready);
	assign pos_last  = (pos_q == POS_W'(REPORT_BYTES - 1));

	// skip phases an entry does not have
	always_comb begin
		eff_state = state_q;
		if (eff_state == ST_HDR && q_entry.hdr == hmf_pkg::HDR_NONE) begin
			eff_state = ST_DATA;
		end
		if (eff_state == ST_DATA && !q_entry.has_data) begin
			eff_state = ST_PAD;
		end
	end

	// select the byte and the next step
	always_comb begin
		word     = '0;
		q_pop    = 1'b0;
		state_nx = eff_state;
		idx_nx   = idx_q;
		pos_nx   = pos_q + POS_W'(1);
		hdr_last = 1'b0;
		case (eff_state)
			ST_HDR: begin
				case (idx_q)
					3'd0:    word.report_byte = q_entry.channel_id[31:24];
					3'd1:    word.report_byte = q_entry.channel_id[23:16];
					3'd2:    word.report_byte = q_entry.channel_id[15:8];
					3'd3:    word.report_byte = q_entry.channel_id[7:0];
					3'd4:    word.report_byte = (q_entry.hdr == hmf_pkg::HDR_INIT) ?
						q_entry.command_byte : q_entry.seq;
					3'd5:    word.report_byte = q_entry.message_length[15:8];
					default: word.report_byte = q_entry.message_length[7:0];
				endcase
				if (q_entry.hdr == hmf_pkg::HDR_INIT) begin
					hdr_last = (idx_q == 3'(hmf_pkg::INIT_HDR_BYTES - 1));
				end else begin
					hdr_last = (idx_q == 3'(hmf_pkg::CONT_HDR_BYTES - 1));
				end
				if (hdr_last) begin
					state_nx = ST_DATA;
					idx_nx   = 3'd0;
				end else begin
					idx_nx = idx_q + 3'd1;
				end
			end
			ST_DATA: begin
				word.report_byte = q_entry.data_byte;
				if (!q_entry.finish) begin
					q_pop    = 1'b1;
					state_nx = ST_HDR;
				end else if (pos_last) begin
					word.end_of_report  = 1'b1;
					word.end_of_message = q_entry.last;
					q_pop    = 1'b1;
					state_nx = ST_HDR;
					pos_nx   = '0;
				end else begin
					state_nx = ST_PAD;
				end
			end
			default: begin
				word.report_byte = 8'd0;
				if (pos_last) begin
					word.end_of_report  = 1'b1;
					word.end_of_message = q_entry.last;
					q_pop    = 1'b1;
					state_nx = ST_HDR;
					pos_nx   = '0;
				end
			end
		endcase
		if (!advance) begin
			q_pop = 1'b0;
		end
	end

	// sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_HDR;
			idx_q       <= 3'd0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nx;
				idx_q       <= idx_nx;
				pos_q       <= pos_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= word;
		end
	end

endmodule

### rtl/core/hmf_checker.sv
// hmf_checker: port-level checks of the hid message fragmenter
// bound to hid_message_fragmenter; depends on hmf_pkg
module hmf_checker #(
	parameter int unsigned REPORT_BYTES = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input hmf_pkg::out_word_t out_data
);

	localparam int unsigned POS_W = $clog2(REPORT_BYTES);

	logic [POS_W-1:0] pos_q;

	// bytes taken so far in the current report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (out_valid && out_ready) begin
			pos_q <= out_data.end_of_report ? '0 : pos_q + POS_W'(1);
		end
	end

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// message end only on a report end
	a_eom_eor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.end_of_message |-> out_data.end_of_report)
		else $error("end of message without end of report");

	// report end exactly on the last byte of a report
	a_eor_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.end_of_report == (pos_q == POS_W'(REPORT_BYTES - 1))))
		else $error("report length mismatch");

	// first byte after reset is a report start: the report counter sits at zero
	a_reset_pos: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> pos_q == '0)
		else $error("report counter not cleared by reset");

endmodule

bind hid_message_fragmenter hmf_checker #(
	.REPORT_BYTES (REPORT_BYTES)
) u_hmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
